// ===== hdl/rtd_pkg.sv =====
// Shared types and constants for the rtime decompressor.
// No dependencies; imported by rtd_engine, rtd_packer and rtime_decompressor_unit.
package rtd_pkg;

    // Page history and pointer sizing
    localparam int PAGE_BYTES = 4096;
    localparam int HIST_AW    = $clog2(PAGE_BYTES);
    localparam int PTR_W      = $clog2(PAGE_BYTES + 1);

    // Position table, one entry per byte value
    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = $clog2(SYMBOL_COUNT);

    // Output packing
    localparam int BYTES_PER_RESULT = 8;
    localparam int BYTE_IDX_W       = $clog2(BYTES_PER_RESULT);
    localparam int CNT_W            = 4;
    localparam int WORD_W           = 8 * BYTES_PER_RESULT;
    localparam int IN_TDATA_W       = 16;
    localparam int OUT_TDATA_W      = 72;

    // Configuration port
    localparam int LEN_W      = 13;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_PAGE_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] PAGE_LENGTH_RESET = LEN_W'(4096);

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIT,
        ST_COPY
    } t_state;

    // One byte handed from the engine to the packer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       full;
    } t_push;

endpackage

// ===== hdl/rtd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first: a read at the address being written returns the old data.
// No dependencies.
module rtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Registered read, then write
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

endmodule

// ===== hdl/rtd_engine.sv =====
// Copy engine: page history RAM, last-position RAM with valid bits, write
// pointer and the per-pair sequencer. Depends on rtd_pkg and rtd_ram.
module rtd_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_literal,
    input  logic [7:0]                i_repeat,
    input  logic                      i_page_start,
    input  logic [rtd_pkg::PTR_W-1:0] i_limit,
    input  logic                      i_push_ok,
    output rtd_pkg::t_push            o_push
);
    import rtd_pkg::*;

    t_state             r_state, n_state;
    logic [SYM_W-1:0]   r_lit, n_lit;
    logic [7:0]         r_rem, n_rem;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_src, n_src;
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic               r_byp;
    logic [7:0]         r_byp_data;

    logic               accept;
    logic               push_req;
    logic               push_fire;
    logic               can_write;
    logic               is_last;
    logic               is_full;
    logic [PTR_W-1:0]   wp_inc;
    logic [PTR_W-1:0]   lp_src;
    logic [7:0]         byte_now;

    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr;
    logic [HIST_AW-1:0] hist_raddr;
    logic [7:0]         hist_rdata;
    logic               lp_we;
    logic [SYM_W-1:0]   lp_raddr;
    logic [PTR_W-1:0]   lp_rdata;

    // Memories
    rtd_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (byte_now),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    rtd_ram #(.WIDTH(PTR_W), .DEPTH(SYMBOL_COUNT)) u_lpos (
        .i_clk   (i_clk),
        .i_we    (lp_we),
        .i_waddr (r_lit),
        .i_wdata (wp_inc),
        .i_raddr (lp_raddr),
        .o_rdata (lp_rdata)
    );

    // Datapath terms
    assign o_ready   = (r_state == ST_IDLE);
    assign accept    = i_valid && o_ready;
    assign can_write = (r_wp < i_limit);
    assign wp_inc    = r_wp + PTR_W'(1);
    assign is_full   = (wp_inc >= i_limit);
    assign lp_src    = r_valid[r_lit] ? lp_rdata : '0;
    // entry not valid since the page start reads as zero
    assign byte_now  = (r_state == ST_LIT) ? r_lit
                     : (r_byp ? r_byp_data : hist_rdata);
    assign lp_raddr  = (r_state == ST_IDLE) ? i_literal : r_lit;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_lit      = r_lit;
        n_rem      = r_rem;
        n_wp       = r_wp;
        n_src      = r_src;
        push_req   = 1'b0;
        is_last    = 1'b0;
        hist_raddr = r_src[HIST_AW-1:0];
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_lit   = i_literal;
                    n_rem   = i_repeat;
                    n_wp    = i_page_start ? '0 : r_wp;
                    n_state = ST_LIT;
                end
            end
            ST_LIT: begin
                hist_raddr = lp_src[HIST_AW-1:0];
                is_last    = (r_rem == 8'd0) || is_full;
                if (!can_write) begin
                    // page already full: the pair is dropped whole
                    n_state = ST_IDLE;
                end else begin
                    push_req = 1'b1;
                    if (i_push_ok) begin
                        n_src   = lp_src;
                        n_wp    = wp_inc;
                        n_state = is_last ? ST_IDLE : ST_COPY;
                    end
                end
            end
            ST_COPY: begin
                push_req = 1'b1;
                is_last  = (r_rem == 8'd1) || is_full;
                if (i_push_ok) begin
                    hist_raddr = HIST_AW'(r_src + PTR_W'(1));
                    n_src      = r_src + PTR_W'(1);
                    n_wp       = wp_inc;
                    n_rem      = r_rem - 8'd1;
                    n_state    = is_last ? ST_IDLE : ST_COPY;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign push_fire  = push_req && i_push_ok;
    assign hist_we    = push_fire;
    assign hist_waddr = r_wp[HIST_AW-1:0];
    assign lp_we      = push_fire && (r_state == ST_LIT);

    assign o_push.valid = push_fire;
    assign o_push.data  = byte_now;
    assign o_push.last  = is_last;
    assign o_push.full  = is_last && is_full;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp    <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            // read and write of one entry in the same cycle: forward the byte
            r_byp   <= hist_we && (hist_raddr == hist_waddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_lit      <= n_lit;
        r_rem      <= n_rem;
        r_src      <= n_src;
        r_byp_data <= byte_now;
    end

    // Position table valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (accept && i_page_start) begin
            r_valid <= '0;
        end else if (lp_we) begin
            r_valid[r_lit] <= 1'b1;
        end
    end

    // Checks
    a_push_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> (r_wp < i_limit))
        else $error("byte pushed at or beyond the page limit");

    a_copy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> (r_rem != 8'd0))
        else $error("copy state with no bytes left");

    a_last_ends_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after last byte");

    a_wp_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |=> (r_wp == $past(r_wp) + PTR_W'(1)))
        else $error("write pointer did not advance with a pushed byte");

endmodule

// ===== hdl/rtd_packer.sv =====
// Output packer: gathers bytes into words of up to eight and holds one
// finished word in the output register. Depends on rtd_pkg.
module rtd_packer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rtd_pkg::t_push             i_push,
    output logic                       o_push_ok,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rtd_pkg::WORD_W-1:0] o_bytes,
    output logic [rtd_pkg::CNT_W-1:0]  o_count,
    output logic                       o_last,
    output logic                       o_full
);
    import rtd_pkg::*;

    logic [WORD_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]  r_acc_cnt, n_acc_cnt;
    logic              r_acc_done;
    logic              r_acc_last;
    logic              r_acc_full;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_bytes;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_last;
    logic              r_out_full;

    logic              flush;
    logic [WORD_W-1:0] base_acc;
    logic [CNT_W-1:0]  base_cnt;

    // A finished word moves out when the output register is free or drains
    assign flush     = r_acc_done && (!r_out_valid || i_ready);
    assign o_push_ok = !r_acc_done || flush;

    // Byte insertion into the lane after the last filled one
    always_comb begin
        base_cnt = r_acc_done ? '0 : r_acc_cnt;
        base_acc = (r_acc_done || (r_acc_cnt == '0)) ? '0 : r_acc;
        n_acc    = base_acc;
        for (int j = 0; j < BYTES_PER_RESULT; j++) begin
            if (base_cnt[BYTE_IDX_W-1:0] == BYTE_IDX_W'(j)) begin
                n_acc[8*j +: 8] = i_push.data;
            end
        end
        n_acc_cnt = base_cnt + CNT_W'(1);
    end

    // Accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt  <= '0;
            r_acc_done <= 1'b0;
        end else if (i_push.valid) begin
            r_acc_cnt  <= n_acc_cnt;
            r_acc_done <= (n_acc_cnt == CNT_W'(BYTES_PER_RESULT)) || i_push.last;
        end else if (flush) begin
            r_acc_cnt  <= '0;
            r_acc_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_acc      <= n_acc;
            r_acc_last <= i_push.last;
            r_acc_full <= i_push.full;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (flush) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (flush) begin
            r_out_bytes <= r_acc;
            r_out_cnt   <= r_acc_cnt;
            r_out_last  <= r_acc_last;
            r_out_full  <= r_acc_full;
        end
    end

    assign o_valid = r_out_valid;
    assign o_bytes = r_out_bytes;
    assign o_count = r_out_cnt;
    assign o_last  = r_out_last;
    assign o_full  = r_out_full;

    // Checks
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_cnt <= CNT_W'(BYTES_PER_RESULT)))
        else $error("accumulator byte count out of range");

    a_flush_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush |=> (r_out_valid && (r_out_cnt != '0)))
        else $error("flushed word did not reach the output register");

    a_no_push_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> o_push_ok)
        else $error("byte pushed while the accumulator was held");

endmodule

// ===== hdl/rtime_decompressor_unit.sv =====
// Top level of the rtime page decompressor: configuration register,
// engine and output packer. Depends on rtd_pkg, rtd_engine, rtd_packer.
//
// Usage:
//   Input stream: one (literal, repeat) pair per item; tdata[7:0] literal,
//   tdata[15:8] repeat count, tuser is page_start (clears the position
//   table and the write pointer before the pair).
//   Output stream: tdata[63:0] up to eight bytes (first in bits 7:0),
//   tdata[67:64] byte count; tlast marks the final item of a pair, tuser is
//   page_full on that item. A pair whose bytes are all dropped gives none.
//   APB register 0 (address 0): page_length, 13 bits, reset 4096.
// Timing: one pair is worked at a time. Its repeat_count + 1 bytes are made
//   one per cycle while the packer accepts them (fewer when the page fills),
//   a rate set by the single read port of the page history RAM and its read-modify-write loop.
//   An output item passes the accumulator and the output register once its word is full or the pair ends.
// Reset: synchronous, clears the write pointer, the position table valid
//   bits and all handshake state; page_length returns to 4096.
// Stall: one finished item waits in the output register and one in the
//   accumulator; the engine then holds until the receiver takes an item.
module rtime_decompressor_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [rtd_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // literal_byte, repeat_count
    input  logic                              i_s_tuser,  // page_start
    // result items
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rtd_pkg::OUT_TDATA_W-1:0]   o_m_tdata,  // out_bytes, byte_count, pad
    output logic                              o_m_tlast,  // last_of_pair
    output logic                              o_m_tuser,  // page_full
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rtd_pkg::APB_AW-1:0]        paddr,
    input  logic [rtd_pkg::APB_DW-1:0]        pwdata,
    output logic [rtd_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import rtd_pkg::*;

    logic [LEN_W-1:0]     r_page_length;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [PTR_W-1:0]     limit;
    t_push                push;
    logic                 push_ok;
    logic [WORD_W-1:0]    out_bytes;
    logic [CNT_W-1:0]     out_cnt;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1 -: REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_length <= PAGE_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == REG_PAGE_LENGTH)) begin
            r_page_length <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_PAGE_LENGTH) ? APB_DW'(r_page_length) : '0;

    // Effective limit, clipped to the history size
    assign limit = (PTR_W'(r_page_length) > PTR_W'(PAGE_BYTES))
                 ? PTR_W'(PAGE_BYTES) : PTR_W'(r_page_length);

    rtd_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_literal    (i_s_tdata[7:0]),
        .i_repeat     (i_s_tdata[15:8]),
        .i_page_start (i_s_tuser),
        .i_limit      (limit),
        .i_push_ok    (push_ok),
        .o_push       (push)
    );

    rtd_packer u_packer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_push_ok (push_ok),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_bytes   (out_bytes),
        .o_count   (out_cnt),
        .o_last    (o_m_tlast),
        .o_full    (o_m_tuser)
    );

    assign o_m_tdata = {(OUT_TDATA_W - WORD_W - CNT_W)'(0), out_cnt, out_bytes};

endmodule
